// ===== rtl/gear_content_defined_chunker_defines.svh =====
// Assertion macros shared by the chunker RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GEAR_CONTENT_DEFINED_CHUNKER_DEFINES_SVH
`define GEAR_CONTENT_DEFINED_CHUNKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GCDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gcdc_pkg.sv =====
// Types, constants and the gear lookup table of the content-defined chunker.
// Depends on nothing; imported by the interfaces and all RTL modules.
package gcdc_pkg;

	localparam int LEN_W  = 25;
	localparam int MASK_W = 32;
	localparam int HASH_W = 32;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 25'h100_0000;
	localparam logic [LEN_W-1:0]  MIN_LEN_RESET = 25'(16 * 1024);
	localparam logic [MASK_W-1:0] MASK_RESET    = 32'((64 * 1024) - 1);

	localparam logic [63:0] GOLDEN_C = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX1_C   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX2_C   = 64'h94d0_49bb_1331_11eb;

	typedef enum logic [1:0] {
		REG_MAX_LEN = 2'd0,
		REG_MIN_LEN = 2'd1,
		REG_MASK    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0]  max_len;
		logic [LEN_W-1:0]  min_len;
		logic [MASK_W-1:0] mask;
	} cfg_t;

	// Only the low bits of the hash ever meet the mask, and they depend only
	// on the low bits of the gear values, so the table keeps those.
	typedef logic [HASH_W-1:0] gear_table_t [256];

	function automatic gear_table_t build_gear_table();
		logic [63:0] v;
		gear_table_t t;
		for (int i = 0; i < 256; i++) begin
			v = 64'(i) + GOLDEN_C;
			v = (v ^ (v >> 30)) * MIX1_C;
			v = (v ^ (v >> 27)) * MIX2_C;
			v = v ^ (v >> 31);
			t[i] = v[HASH_W-1:0];
		end
		return t;
	endfunction

	localparam gear_table_t GEAR_TABLE = build_gear_table();

endpackage

// ===== rtl/gcdc_if.sv =====
// Valid/ready stream interfaces for byte input and chunk results.
// Depends on gcdc_pkg for field widths.
interface gcdc_in_if import gcdc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface gcdc_out_if import gcdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] chunk_length;
	logic             stream_done;

	modport source (output valid, output chunk_length, output stream_done, input ready);
	modport sink (input valid, input chunk_length, input stream_done, output ready);
endinterface

// ===== rtl/gcdc_regs.sv =====
// APB-style configuration registers of the chunker.
// Depends on gcdc_pkg for register indexes, widths and reset values.
module gcdc_regs import gcdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_len <= MAX_LEN_RESET;
			cfg_q.min_len <= MIN_LEN_RESET;
			cfg_q.mask    <= MASK_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAX_LEN: cfg_q.max_len <= pwdata[LEN_W-1:0];
				REG_MIN_LEN: cfg_q.min_len <= pwdata[LEN_W-1:0];
				REG_MASK:    cfg_q.mask    <= pwdata[MASK_W-1:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_LEN: prdata = DATA_W'(cfg_q.max_len);
			REG_MIN_LEN: prdata = DATA_W'(cfg_q.min_len);
			REG_MASK:    prdata = DATA_W'(cfg_q.mask);
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/gear_content_defined_chunker.sv =====
// A byte accepted is captured in the input stage (gear_s1, eod_s1); a chunk it closes is registered as the result.
// Throughput: one byte per cycle unless a pending chunk result is held by chunks.ready low.
// The gear table lookup happens at input capture; the hash add and mask test follow.
// Reset clears hash, byte count and both valid flags; registers return to defaults.
// Depends on gcdc_pkg, gcdc_if, gcdc_regs and the assertion macro header.
`include "gear_content_defined_chunker_defines.svh"

module gear_content_defined_chunker import gcdc_pkg::*; #(
	parameter int unsigned MAX_CHUNK_LIMIT = 16777216
) (
	input  logic              clk,
	input  logic              arst_n,
	gcdc_in_if.sink           stream,
	gcdc_out_if.source        chunks,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [LEN_W-1:0] LIMIT_C = LEN_W'(MAX_CHUNK_LIMIT);

	cfg_t              cfg;
	logic [LEN_W-1:0]  eff_max;

	logic              valid_s1;
	logic [HASH_W-1:0] gear_s1;
	logic              eod_s1;

	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_done_q;

	logic              advance;
	logic              accept;
	logic [HASH_W-1:0] hash_nxt;
	logic [LEN_W-1:0]  cnt_nxt;
	logic              cut;

	gcdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		priority if (cfg.max_len == '0) begin
			eff_max = LEN_W'(1);
		end else if (cfg.max_len > LIMIT_C) begin
			eff_max = LIMIT_C;
		end else begin
			eff_max = cfg.max_len;
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || chunks.ready);
	assign stream.ready = !valid_s1 || advance;
	assign accept       = stream.valid && stream.ready;

	assign hash_nxt = {hash_q[HASH_W-2:0], 1'b0} + gear_s1;
	assign cnt_nxt  = cnt_q + LEN_W'(1);
	assign cut      = eod_s1 || (cnt_nxt >= eff_max) ||
		((cnt_nxt >= cfg.min_len) && ((hash_nxt & cfg.mask) == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gear_s1 <= GEAR_TABLE[stream.data_byte];
			eod_s1  <= stream.end_of_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cut;
			if (cut) begin
				hash_q <= '0;
				cnt_q  <= '0;
			end else begin
				hash_q <= hash_nxt;
				cnt_q  <= cnt_nxt;
			end
		end else if (chunks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cut) begin
			out_len_q  <= cnt_nxt;
			out_done_q <= eod_s1;
		end
	end

	assign chunks.valid        = out_valid_q;
	assign chunks.chunk_length = out_len_q;
	assign chunks.stream_done  = out_done_q;

	`GCDC_ASSERT_IMP(a_len_range, clk, arst_n, out_valid_q,
		(out_len_q != '0) && (out_len_q <= LIMIT_C), "chunk length out of range")
	`GCDC_ASSERT_IMP(a_cnt_below_limit, clk, arst_n, 1'b1, cnt_q < LIMIT_C,
		"open chunk count reached the limit")
	`GCDC_ASSERT_NXT(a_eod_closes, clk, arst_n, advance && eod_s1,
		out_valid_q && out_done_q && (cnt_q == '0) && (hash_q == '0),
		"final byte did not close the chunk")
	`GCDC_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(gear_s1) && $stable(eod_s1), "stalled input stage changed")

endmodule
